### rtl/lcdt_pkg.sv
// Shared types and timing constants for the LCD mode timing block.
package lcdt_pkg;

   typedef enum logic [1:0] {
      MODE_HREST = 2'd0,
      MODE_VREST = 2'd1,
      MODE_SCAN  = 2'd2,
      MODE_XFER  = 2'd3
   } mode_type;

   localparam int DotWidth  = 10;
   localparam int LineWidth = 8;
   localparam int TickWidth = 6;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 8;

   localparam logic [DotWidth-1:0] DotsOam   = 10'd80;
   localparam logic [DotWidth-1:0] DotsXfer  = 10'd172;
   localparam logic [DotWidth-1:0] DotsHblank = 10'd204;
   localparam logic [DotWidth-1:0] DotsLine  = 10'd456;

   localparam logic [LineWidth-1:0] VisibleLines = 8'd144;
   localparam logic [LineWidth-1:0] LastLine     = 8'd153;

   localparam logic [CsrIdxWidth-1:0] CsrLcdEnable   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrLycValue    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrHblankIntEn = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrVblankIntEn = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrOamIntEn    = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CsrLycIntEn    = 3'd5;

   typedef struct packed {
      logic                 lcd_enable;
      logic [LineWidth-1:0] lyc_value;
      logic                 hblank_int_en;
      logic                 vblank_int_en;
      logic                 oam_int_en;
      logic                 lyc_int_en;
   } cfg_type;

   typedef struct packed {
      logic [DotWidth-1:0]  dot_count;
      logic [LineWidth-1:0] line_count;
      mode_type             internal_mode;
      mode_type             shown_mode;
      logic                 coincidence_flag;
      logic                 frame_flag;
   } timing_state_type;

   typedef struct packed {
      logic [LineWidth-1:0] line;
      logic [1:0]           stat_mode;
      logic                 coincidence;
      logic                 stat_irq;
      logic                 vblank_irq;
      logic                 frame_done;
      logic                 render_request;
   } result_type;

endpackage

### rtl/lcdt_ifs.sv
// Handshake channel interfaces for tick words and result words.
interface lcdt_req_if
   import lcdt_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [TickWidth-1:0] cycles;

   modport source (output valid, output cycles, input ready);
   modport sink   (input valid, input cycles, output ready);
endinterface

interface lcdt_rsp_if
   import lcdt_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [LineWidth-1:0] line;
   logic [1:0]           stat_mode;
   logic                 coincidence;
   logic                 stat_irq;
   logic                 vblank_irq;
   logic                 frame_done;
   logic                 render_request;

   modport source (output valid, output line, output stat_mode, output coincidence,
                   output stat_irq, output vblank_irq, output frame_done,
                   output render_request, input ready);
   modport sink   (input valid, input line, input stat_mode, input coincidence,
                   input stat_irq, input vblank_irq, input frame_done,
                   input render_request, output ready);
endinterface

### rtl/lcd_mode_timing_fsm_top.sv
// Top level of the LCD mode timing block: state, result register and handshakes.
//
//   channel  | direction | word contents
//   req_ch   | in        | cycles
//   rsp_ch   | out       | line, stat_mode, coincidence, irqs, frame_done, render_request
//   csr_*    | in        | register index and write data, write enable
//
// One tick word is accepted per cycle unless a result stalls; its result is registered.
// The timing state updates at acceptance, through one pass of the step logic.
// The result register frees itself when taken, so a new word enters while the
// previous result is being taken; a stalled result holds the input side.
// Synchronous reset puts the display on, in vblank on line 0 with no result pending.
module lcd_mode_timing_fsm_top
   import lcdt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   lcdt_req_if.sink                req_ch,
   lcdt_rsp_if.source              rsp_ch,
   input  logic                    csr_we,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata
);
   cfg_type          cfg;
   timing_state_type state_ff, state_in;
   result_type       res_ff, res_in;
   logic             rsp_valid_ff;
   logic             accept;

   lcdt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcdt_step u_step (
      .cur    (state_ff),
      .cfg    (cfg),
      .cycles (req_ch.cycles),
      .nxt    (state_in),
      .res    (res_in)
   );

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.dot_count        <= '0;
         state_ff.line_count       <= '0;
         state_ff.internal_mode    <= MODE_VREST;
         state_ff.shown_mode       <= MODE_VREST;
         state_ff.coincidence_flag <= 1'b0;
         state_ff.frame_flag       <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.line           = res_ff.line;
   assign rsp_ch.stat_mode      = res_ff.stat_mode;
   assign rsp_ch.coincidence    = res_ff.coincidence;
   assign rsp_ch.stat_irq       = res_ff.stat_irq;
   assign rsp_ch.vblank_irq     = res_ff.vblank_irq;
   assign rsp_ch.frame_done     = res_ff.frame_done;
   assign rsp_ch.render_request = res_ff.render_request;

   // The line counter never rests beyond the last line.
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.line_count <= LastLine)
      else $error("line counter beyond last line");

   // A render request only comes with the move into transfer on a visible line.
   a_render_xfer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_ff.render_request) |->
         (res_ff.stat_mode == MODE_XFER && res_ff.line < VisibleLines))
      else $error("render request outside transfer entry");

   // A vblank interrupt marks entry into vblank on the first vblank line.
   a_vblank_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_ff.vblank_irq) |->
         (res_ff.stat_mode == MODE_VREST && res_ff.line == VisibleLines &&
          res_ff.frame_done))
      else $error("vblank interrupt without vblank entry");

   // A tick taken with the display off leaves the block parked at line 0 in OAM.
   a_display_off: assert property (@(posedge clock) disable iff (reset)
      (accept && !cfg.lcd_enable) |=>
         (rsp_valid_ff && res_ff.line == '0 && res_ff.stat_mode == MODE_HREST &&
          !res_ff.stat_irq && state_ff.internal_mode == MODE_SCAN &&
          state_ff.dot_count == '0))
      else $error("display off did not park the sequencer");
endmodule

### rtl/lcdt_csr.sv
// Configuration registers of the LCD mode timing block.
module lcdt_csr
   import lcdt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output cfg_type                 cfg
);
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CsrLcdEnable:   cfg_in.lcd_enable    = csr_wdata[0];
            CsrLycValue:    cfg_in.lyc_value     = csr_wdata[LineWidth-1:0];
            CsrHblankIntEn: cfg_in.hblank_int_en = csr_wdata[0];
            CsrVblankIntEn: cfg_in.vblank_int_en = csr_wdata[0];
            CsrOamIntEn:    cfg_in.oam_int_en    = csr_wdata[0];
            CsrLycIntEn:    cfg_in.lyc_int_en    = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lcd_enable    <= 1'b1;
         cfg_ff.lyc_value     <= '0;
         cfg_ff.hblank_int_en <= 1'b0;
         cfg_ff.vblank_int_en <= 1'b0;
         cfg_ff.oam_int_en    <= 1'b0;
         cfg_ff.lyc_int_en    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

### rtl/lcdt_step.sv
// Next-state and result logic for one tick of the mode timing sequencer.
module lcdt_step
   import lcdt_pkg::*;
(
   input  timing_state_type     cur,
   input  cfg_type              cfg,
   input  logic [TickWidth-1:0] cycles,
   output timing_state_type     nxt,
   output result_type           res
);
   logic [DotWidth-1:0]  dot_sum;
   logic [LineWidth-1:0] line_inc;
   logic                 line_match;
   logic                 stat;
   logic                 vb_irq;
   logic                 render;

   assign dot_sum    = cur.dot_count + {{(DotWidth-TickWidth){1'b0}}, cycles};
   assign line_inc   = cur.line_count + 8'd1;
   assign line_match = (line_inc == cfg.lyc_value);

   always_comb begin
      nxt    = cur;
      stat   = 1'b0;
      vb_irq = 1'b0;
      render = 1'b0;
      if (!cfg.lcd_enable) begin
         nxt.dot_count     = '0;
         nxt.line_count    = '0;
         nxt.internal_mode = MODE_SCAN;
         nxt.shown_mode    = MODE_HREST;
         nxt.frame_flag    = 1'b0;
      end else begin
         nxt.dot_count = dot_sum;
         unique case (cur.internal_mode)
            MODE_HREST: begin
               if (dot_sum >= DotsHblank) begin
                  nxt.dot_count        = dot_sum - DotsHblank;
                  nxt.line_count       = line_inc;
                  nxt.coincidence_flag = line_match;
                  stat = line_match && cfg.lyc_int_en;
                  if (line_inc == VisibleLines) begin
                     nxt.internal_mode = MODE_VREST;
                     nxt.shown_mode    = MODE_VREST;
                     nxt.frame_flag    = 1'b1;
                     vb_irq = 1'b1;
                     stat   = stat || cfg.vblank_int_en;
                  end else begin
                     nxt.internal_mode = MODE_SCAN;
                     nxt.shown_mode    = MODE_SCAN;
                     nxt.frame_flag    = 1'b0;
                     stat = stat || cfg.oam_int_en;
                  end
               end
            end
            MODE_VREST: begin
               if (dot_sum >= DotsLine) begin
                  nxt.dot_count        = dot_sum - DotsLine;
                  nxt.line_count       = line_inc;
                  nxt.coincidence_flag = line_match;
                  stat = line_match && cfg.lyc_int_en;
                  // Leaving the last line wraps the counter without a second compare.
                  if (line_inc > LastLine) begin
                     nxt.line_count    = '0;
                     nxt.internal_mode = MODE_SCAN;
                     nxt.shown_mode    = MODE_SCAN;
                     stat = stat || cfg.oam_int_en;
                  end
               end
            end
            MODE_SCAN: begin
               if (dot_sum >= DotsOam) begin
                  nxt.dot_count     = dot_sum - DotsOam;
                  render            = (cur.line_count < VisibleLines);
                  nxt.internal_mode = MODE_XFER;
                  nxt.shown_mode    = MODE_XFER;
               end
            end
            MODE_XFER: begin
               if (dot_sum >= DotsXfer) begin
                  nxt.dot_count     = dot_sum - DotsXfer;
                  nxt.internal_mode = MODE_HREST;
                  nxt.shown_mode    = MODE_HREST;
                  stat = cfg.hblank_int_en;
               end
            end
            default: nxt = cur;
         endcase
      end
   end

   assign res.line           = nxt.line_count;
   assign res.stat_mode      = nxt.shown_mode;
   assign res.coincidence    = nxt.coincidence_flag;
   assign res.stat_irq       = stat;
   assign res.vblank_irq     = vb_irq;
   assign res.frame_done     = nxt.frame_flag;
   assign res.render_request = render;
endmodule
